// ----- sv/vpk0_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vpk0_pkg;

  localparam int HISTORY_DEPTH = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int DIST_W        = HIST_AW + 1;
  localparam int NODE_POOL     = 64;
  localparam int NODE_AW       = $clog2(NODE_POOL);
  localparam int NODE_CW       = $clog2(NODE_POOL + 1);
  localparam int STACK_DEPTH   = 20;
  localparam int STACK_AW      = $clog2(STACK_DEPTH);
  localparam int STACK_CW      = $clog2(STACK_DEPTH + 1);
  localparam int MAX_BYTES     = 32;
  localparam int BCNT_W        = $clog2(MAX_BYTES + 1);
  localparam int BQ_DEPTH      = 2 * MAX_BYTES;
  localparam int BQ_AW         = $clog2(BQ_DEPTH);
  localparam int SV_W          = 36;

  localparam logic CMD_SUPPLY = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_OVERFLOW   = 2'd1,
    ERR_EMPTY_TREE = 2'd2,
    ERR_BAD_OFFSET = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_SIZE, PH_METHOD, PH_OTREE, PH_OLEAF, PH_LTREE, PH_LLEAF,
    PH_FLAG, PH_LITERAL, PH_WALK, PH_FIELD, PH_DONE, PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    SUB_FIRST, SUB_SECOND, SUB_LEN
  } sub_e;

  typedef enum logic [1:0] {
    E_IDLE, E_RUN, E_NODE, E_COPY
  } eng_e;

  typedef enum logic [2:0] {
    S_FINISH, S_LIT, S_COPY, S_DONE, S_ACT, S_SHIFT
  } step_e;

  typedef enum logic [1:0] {
    B_IDLE, B_LOAD, B_HOLD
  } back_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       more_pending;
    logic       done_res;
    logic [1:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [BCNT_W-1:0] count;
    logic              more;
    logic              done;
    err_e              err;
  } status_t;

  typedef struct packed {
    logic               leaf;
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic [7:0]         value;
  } node_t;

endpackage

`default_nettype wire

// ----- sv/vpk0_stream_decompressor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Streaming decompressor for LZ data with prefix-coded field widths.
// Input channel (in_valid_i / in_stall_o / in_item_i): each transaction is
// either a 16-bit compressed word (cmd 0) or a drain command (cmd 1) that
// continues a copy paused by the per-transaction byte budget (32 bytes).
// Output channel (out_valid_o / out_stall_i / out_item_o): each input
// transaction yields one or more results, one per decompressed byte or a
// single status-only result; the final one carries last. Status fields
// (more_pending, done_res, error_code) describe the state after the whole
// input transaction and are repeated on each of its results.
// Per transaction the decoder accepts it, then shifts each stream bit and
// acts on each field, reads a node for each tree node entered, writes each
// literal byte, reads then writes history for each copied byte, and last
// posts the status. Each result is read from the byte queue into an output
// register and held there until out_stall_i is low; a zero-byte status
// result skips the read.
// A holding register takes the next transaction while the decoder works,
// and a byte queue of two transactions lets the decoder continue while the
// receiver stalls; once the queue is full, in_stall_o stays high.
// Reset clears all control state; history, node pool and build stack need
// no clearing, as nothing reads an entry before it is written.

module vpk0_stream_decompressor (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  output logic                      in_stall_o,
  input  wire vpk0_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire                 logic out_stall_i,
  output vpk0_pkg::out_item_t       out_item_o
);

  logic              space_ok;
  logic              st_push;
  vpk0_pkg::status_t st;
  logic              bq_push;
  logic [7:0]        bq_byte;

  // front: bit buffer, tree build and walk, history
  vpk0_dec u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .space_ok_i (space_ok),
    .st_push_o  (st_push),
    .st_o       (st),
    .bq_push_o  (bq_push),
    .bq_byte_o  (bq_byte)
  );

  // back: byte queue and result sequencing
  vpk0_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_push_i   (st_push),
    .st_i        (st),
    .bq_push_i   (bq_push),
    .bq_byte_i   (bq_byte),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- sv/vpk0_dec.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vpk0_dec (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic                     in_stall_o,
  input  wire vpk0_pkg::in_item_t  in_item_i,
  input  wire                logic space_ok_i,
  output logic                     st_push_o,
  output vpk0_pkg::status_t        st_o,
  output logic                     bq_push_o,
  output logic [7:0]               bq_byte_o
);

  localparam logic signed [vpk0_pkg::SV_W-1:0] HistLim =
    vpk0_pkg::SV_W'(vpk0_pkg::HISTORY_DEPTH);
  localparam logic signed [vpk0_pkg::SV_W-1:0] Eight = vpk0_pkg::SV_W'(8);

  // input holding register
  logic               in_full_q, in_full_d;
  vpk0_pkg::in_item_t in_q;

  vpk0_pkg::eng_e   eng_q, eng_d;
  vpk0_pkg::phase_e phase_q, phase_d;
  vpk0_pkg::sub_e   sub_q, sub_d;
  vpk0_pkg::err_e   err_q, err_d;
  vpk0_pkg::step_e  step;

  logic [7:0]  need_q, need_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] buf_q, buf_d;
  logic [5:0]  bcnt_q, bcnt_d;
  logic [31:0] size_q, size_d;
  logic [31:0] ocnt_q, ocnt_d;
  logic        two_q, two_d;
  logic [vpk0_pkg::NODE_CW-1:0]  used_q, used_d;
  logic [vpk0_pkg::STACK_CW-1:0] fill_q, fill_d;
  logic [vpk0_pkg::NODE_AW-1:0]  top_q, top_d;
  logic        oroot_vld_q, oroot_vld_d, lroot_vld_q, lroot_vld_d;
  logic [vpk0_pkg::NODE_AW-1:0]  oroot_q, oroot_d, lroot_q, lroot_d;
  logic signed [vpk0_pkg::SV_W-1:0] extra_q, extra_d, pend_q, pend_d;
  logic [30:0] crem_q, crem_d;
  logic [vpk0_pkg::DIST_W-1:0] cdist_q, cdist_d;
  logic        lit_pend_q, lit_pend_d;
  logic [7:0]  lit_q, lit_d;
  logic [vpk0_pkg::HIST_AW-1:0] hpos_q, hpos_d;
  logic [vpk0_pkg::BCNT_W-1:0]  n_q, n_d;

  // node pool, build stack, history
  vpk0_pkg::node_t node_mem [vpk0_pkg::NODE_POOL];
  vpk0_pkg::node_t node_rd_q, node_wd;
  logic            node_we, node_rd_en;
  logic [vpk0_pkg::NODE_AW-1:0] node_wa, node_ra;

  logic [vpk0_pkg::NODE_AW-1:0]  stk_mem [vpk0_pkg::STACK_DEPTH];
  logic                          stk_we;
  logic [vpk0_pkg::STACK_AW-1:0] stk_wa, stk_ra;
  logic [vpk0_pkg::NODE_AW-1:0]  stk_rd;

  logic [7:0] hist_mem [vpk0_pkg::HISTORY_DEPTH];
  logic [7:0] hist_rd_q, hist_wd;
  logic       hist_we, hist_rd_en;
  logic [vpk0_pkg::HIST_AW-1:0] hist_ra;

  logic        take, paused, cur_bit;
  logic signed [vpk0_pkg::SV_W-1:0] sv;
  logic [vpk0_pkg::NODE_CW-1:0] used_m1;

  assign in_stall_o = in_full_q;
  assign take       = (eng_q == vpk0_pkg::E_IDLE) && in_full_q && space_ok_i;
  assign paused     = lit_pend_q || (crem_q != '0);
  assign cur_bit    = buf_q[5'(bcnt_q - 6'd1)];
  assign sv         = $signed({{(vpk0_pkg::SV_W-32){acc_q[31]}}, acc_q});
  assign used_m1    = used_q - vpk0_pkg::NODE_CW'(1);
  assign stk_ra     = vpk0_pkg::STACK_AW'(fill_q - vpk0_pkg::STACK_CW'(2));
  assign stk_rd     = stk_mem[stk_ra];

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_rd_en) begin
      node_rd_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hpos_q] <= hist_wd;
    end
    if (hist_rd_en) begin
      hist_rd_q <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_full_q) begin
      in_q <= in_item_i;
    end
  end

  // one step of the decode loop per cycle while the engine is in E_RUN
  always_comb begin
    if (phase_q == vpk0_pkg::PH_DONE || phase_q == vpk0_pkg::PH_ERROR) begin
      step = vpk0_pkg::S_FINISH;
    end else if (paused) begin
      if (n_q >= vpk0_pkg::BCNT_W'(vpk0_pkg::MAX_BYTES)) begin
        step = vpk0_pkg::S_FINISH;
      end else if (lit_pend_q) begin
        step = vpk0_pkg::S_LIT;
      end else begin
        step = vpk0_pkg::S_COPY;
      end
    end else if (phase_q == vpk0_pkg::PH_FLAG && ocnt_q >= size_q) begin
      step = vpk0_pkg::S_DONE;
    end else if (need_q == 8'd0) begin
      step = vpk0_pkg::S_ACT;
    end else if (bcnt_q == 6'd0) begin
      step = vpk0_pkg::S_FINISH;
    end else begin
      step = vpk0_pkg::S_SHIFT;
    end
  end

  always_comb begin
    eng_d = eng_q;
    unique case (eng_q)
      vpk0_pkg::E_IDLE: begin
        if (take) begin
          eng_d = vpk0_pkg::E_RUN;
        end
      end
      vpk0_pkg::E_RUN: begin
        if (step == vpk0_pkg::S_FINISH) begin
          eng_d = vpk0_pkg::E_IDLE;
        end else if (step == vpk0_pkg::S_COPY) begin
          eng_d = vpk0_pkg::E_COPY;
        end else if (node_rd_en) begin
          eng_d = vpk0_pkg::E_NODE;
        end
      end
      vpk0_pkg::E_NODE: eng_d = vpk0_pkg::E_RUN;
      vpk0_pkg::E_COPY: eng_d = vpk0_pkg::E_RUN;
      default:          eng_d = vpk0_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    in_full_d   = in_full_q;
    phase_d     = phase_q;
    sub_d       = sub_q;
    err_d       = err_q;
    need_d      = need_q;
    acc_d       = acc_q;
    buf_d       = buf_q;
    bcnt_d      = bcnt_q;
    size_d      = size_q;
    ocnt_d      = ocnt_q;
    two_d       = two_q;
    used_d      = used_q;
    fill_d      = fill_q;
    top_d       = top_q;
    oroot_vld_d = oroot_vld_q;
    oroot_d     = oroot_q;
    lroot_vld_d = lroot_vld_q;
    lroot_d     = lroot_q;
    extra_d     = extra_q;
    pend_d      = pend_q;
    crem_d      = crem_q;
    cdist_d     = cdist_q;
    lit_pend_d  = lit_pend_q;
    lit_d       = lit_q;
    hpos_d      = hpos_q;
    n_d         = n_q;
    node_we     = 1'b0;
    node_wa     = used_q[vpk0_pkg::NODE_AW-1:0];
    node_wd     = '0;
    node_rd_en  = 1'b0;
    node_ra     = '0;
    stk_we      = 1'b0;
    stk_wa      = vpk0_pkg::STACK_AW'(fill_q - vpk0_pkg::STACK_CW'(1));
    hist_we     = 1'b0;
    hist_wd     = lit_q;
    hist_rd_en  = 1'b0;
    hist_ra     = hpos_q - cdist_q[vpk0_pkg::HIST_AW-1:0];
    st_push_o   = 1'b0;
    bq_push_o   = 1'b0;
    bq_byte_o   = lit_q;

    if (in_valid_i && !in_full_q) begin
      in_full_d = 1'b1;
    end

    unique case (eng_q)
      vpk0_pkg::E_IDLE: begin
        if (take) begin
          in_full_d = 1'b0;
          n_d       = '0;
          // append the word only while decoding can use it
          if (in_q.cmd == vpk0_pkg::CMD_SUPPLY && !paused && bcnt_q <= 6'd16 &&
              phase_q != vpk0_pkg::PH_DONE && phase_q != vpk0_pkg::PH_ERROR) begin
            buf_d  = {buf_q[15:0], in_q.word};
            bcnt_d = bcnt_q + 6'd16;
          end
        end
      end

      vpk0_pkg::E_RUN: begin
        unique case (step)
          vpk0_pkg::S_FINISH: st_push_o = 1'b1;
          vpk0_pkg::S_LIT: begin
            hist_we    = 1'b1;
            bq_push_o  = 1'b1;
            lit_pend_d = 1'b0;
            hpos_d     = hpos_q + 1'b1;
            ocnt_d     = (ocnt_q == '1) ? ocnt_q : ocnt_q + 32'd1;
            n_d        = n_q + 1'b1;
          end
          vpk0_pkg::S_COPY: hist_rd_en = 1'b1;
          vpk0_pkg::S_DONE: phase_d = vpk0_pkg::PH_DONE;
          vpk0_pkg::S_SHIFT: begin
            acc_d  = {acc_q[30:0], cur_bit};
            bcnt_d = bcnt_q - 6'd1;
            need_d = need_q - 8'd1;
          end
          vpk0_pkg::S_ACT: begin
            acc_d = '0;
            unique case (phase_q)
              vpk0_pkg::PH_MAGIC: begin
                phase_d = vpk0_pkg::PH_SIZE;
                need_d  = 8'd32;
              end
              vpk0_pkg::PH_SIZE: begin
                size_d  = acc_q;
                phase_d = vpk0_pkg::PH_METHOD;
                need_d  = 8'd8;
              end
              vpk0_pkg::PH_METHOD: begin
                two_d   = acc_q[7:0] != 8'd0;
                fill_d  = '0;
                phase_d = vpk0_pkg::PH_OTREE;
                need_d  = 8'd1;
              end
              vpk0_pkg::PH_OTREE, vpk0_pkg::PH_LTREE: begin
                if (acc_q[0] && fill_q < vpk0_pkg::STACK_CW'(2)) begin
                  // end of tree: root is the lone stack entry, if any
                  fill_d = '0;
                  need_d = 8'd1;
                  if (phase_q == vpk0_pkg::PH_OTREE) begin
                    oroot_vld_d = fill_q != '0;
                    oroot_d     = top_q;
                    phase_d     = vpk0_pkg::PH_LTREE;
                  end else begin
                    lroot_vld_d = fill_q != '0;
                    lroot_d     = top_q;
                    phase_d     = vpk0_pkg::PH_FLAG;
                  end
                end else if (used_q >= vpk0_pkg::NODE_CW'(vpk0_pkg::NODE_POOL)) begin
                  err_d   = vpk0_pkg::ERR_OVERFLOW;
                  phase_d = vpk0_pkg::PH_ERROR;
                end else if (acc_q[0]) begin
                  // join the top two entries
                  node_we       = 1'b1;
                  node_wd.leaf  = 1'b0;
                  node_wd.left  = stk_rd;
                  node_wd.right = top_q;
                  used_d        = used_q + 1'b1;
                  top_d         = used_q[vpk0_pkg::NODE_AW-1:0];
                  fill_d        = fill_q - 1'b1;
                  need_d        = 8'd1;
                end else if (fill_q >= vpk0_pkg::STACK_CW'(vpk0_pkg::STACK_DEPTH)) begin
                  err_d   = vpk0_pkg::ERR_OVERFLOW;
                  phase_d = vpk0_pkg::PH_ERROR;
                end else begin
                  used_d  = used_q + 1'b1;
                  need_d  = 8'd8;
                  phase_d = (phase_q == vpk0_pkg::PH_OTREE) ? vpk0_pkg::PH_OLEAF
                                                            : vpk0_pkg::PH_LLEAF;
                end
              end
              vpk0_pkg::PH_OLEAF, vpk0_pkg::PH_LLEAF: begin
                node_we       = 1'b1;
                node_wa       = used_m1[vpk0_pkg::NODE_AW-1:0];
                node_wd.leaf  = 1'b1;
                node_wd.value = acc_q[7:0];
                stk_we        = fill_q != '0;
                top_d         = used_m1[vpk0_pkg::NODE_AW-1:0];
                fill_d        = fill_q + 1'b1;
                need_d        = 8'd1;
                phase_d       = (phase_q == vpk0_pkg::PH_OLEAF) ? vpk0_pkg::PH_OTREE
                                                                : vpk0_pkg::PH_LTREE;
              end
              vpk0_pkg::PH_FLAG: begin
                if (acc_q[0]) begin
                  if (!oroot_vld_q) begin
                    err_d   = vpk0_pkg::ERR_EMPTY_TREE;
                    phase_d = vpk0_pkg::PH_ERROR;
                  end else begin
                    sub_d      = vpk0_pkg::SUB_FIRST;
                    node_rd_en = 1'b1;
                    node_ra    = oroot_q;
                  end
                end else begin
                  phase_d = vpk0_pkg::PH_LITERAL;
                  need_d  = 8'd8;
                end
              end
              vpk0_pkg::PH_LITERAL: begin
                lit_pend_d = 1'b1;
                lit_d      = acc_q[7:0];
                phase_d    = vpk0_pkg::PH_FLAG;
                need_d     = 8'd1;
              end
              vpk0_pkg::PH_WALK: begin
                node_rd_en = 1'b1;
                node_ra    = acc_q[0] ? node_rd_q.right : node_rd_q.left;
              end
              vpk0_pkg::PH_FIELD: begin
                if (sub_q == vpk0_pkg::SUB_LEN) begin
                  if (!acc_q[31] && acc_q != '0) begin
                    if (pend_q <= 0 ||
                        pend_q > $signed({{(vpk0_pkg::SV_W-32){1'b0}}, ocnt_q}) ||
                        pend_q > HistLim) begin
                      err_d   = vpk0_pkg::ERR_BAD_OFFSET;
                      phase_d = vpk0_pkg::PH_ERROR;
                    end else begin
                      crem_d  = acc_q[30:0];
                      cdist_d = pend_q[vpk0_pkg::DIST_W-1:0];
                      phase_d = vpk0_pkg::PH_FLAG;
                      need_d  = 8'd1;
                    end
                  end else begin
                    phase_d = vpk0_pkg::PH_FLAG;
                    need_d  = 8'd1;
                  end
                end else if (sub_q == vpk0_pkg::SUB_FIRST && two_q &&
                             (acc_q[31] || acc_q <= 32'd2)) begin
                  // small first sample: fetch a second one
                  extra_d    = sv + 1;
                  sub_d      = vpk0_pkg::SUB_SECOND;
                  node_rd_en = 1'b1;
                  node_ra    = oroot_q;
                end else begin
                  if (sub_q == vpk0_pkg::SUB_SECOND) begin
                    pend_d = (sv <<< 2) + extra_q - Eight;
                  end else if (two_q) begin
                    pend_d = (sv <<< 2) - Eight;
                  end else begin
                    pend_d = sv;
                  end
                  if (!lroot_vld_q) begin
                    err_d   = vpk0_pkg::ERR_EMPTY_TREE;
                    phase_d = vpk0_pkg::PH_ERROR;
                  end else begin
                    sub_d      = vpk0_pkg::SUB_LEN;
                    node_rd_en = 1'b1;
                    node_ra    = lroot_q;
                  end
                end
              end
              default: begin
                err_d   = vpk0_pkg::ERR_OVERFLOW;
                phase_d = vpk0_pkg::PH_ERROR;
              end
            endcase
          end
          default: ;
        endcase
      end

      vpk0_pkg::E_NODE: begin
        acc_d = '0;
        if (node_rd_q.leaf) begin
          phase_d = vpk0_pkg::PH_FIELD;
          need_d  = node_rd_q.value;
        end else begin
          phase_d = vpk0_pkg::PH_WALK;
          need_d  = 8'd1;
        end
      end

      vpk0_pkg::E_COPY: begin
        hist_we   = 1'b1;
        hist_wd   = hist_rd_q;
        bq_push_o = 1'b1;
        bq_byte_o = hist_rd_q;
        crem_d    = crem_q - 31'd1;
        hpos_d    = hpos_q + 1'b1;
        ocnt_d    = (ocnt_q == '1) ? ocnt_q : ocnt_q + 32'd1;
        n_d       = n_q + 1'b1;
      end

      default: ;
    endcase
  end

  assign st_o.count = n_q;
  assign st_o.more  = paused;
  assign st_o.done  = phase_q == vpk0_pkg::PH_DONE;
  assign st_o.err   = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      eng_q       <= vpk0_pkg::E_IDLE;
      phase_q     <= vpk0_pkg::PH_MAGIC;
      sub_q       <= vpk0_pkg::SUB_FIRST;
      err_q       <= vpk0_pkg::ERR_NONE;
      need_q      <= 8'd32;
      acc_q       <= '0;
      buf_q       <= '0;
      bcnt_q      <= '0;
      size_q      <= '0;
      ocnt_q      <= '0;
      two_q       <= 1'b0;
      used_q      <= '0;
      fill_q      <= '0;
      top_q       <= '0;
      oroot_vld_q <= 1'b0;
      oroot_q     <= '0;
      lroot_vld_q <= 1'b0;
      lroot_q     <= '0;
      extra_q     <= '0;
      pend_q      <= '0;
      crem_q      <= '0;
      cdist_q     <= '0;
      lit_pend_q  <= 1'b0;
      lit_q       <= '0;
      hpos_q      <= '0;
      n_q         <= '0;
    end else begin
      in_full_q   <= in_full_d;
      eng_q       <= eng_d;
      phase_q     <= phase_d;
      sub_q       <= sub_d;
      err_q       <= err_d;
      need_q      <= need_d;
      acc_q       <= acc_d;
      buf_q       <= buf_d;
      bcnt_q      <= bcnt_d;
      size_q      <= size_d;
      ocnt_q      <= ocnt_d;
      two_q       <= two_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      top_q       <= top_d;
      oroot_vld_q <= oroot_vld_d;
      oroot_q     <= oroot_d;
      lroot_vld_q <= lroot_vld_d;
      lroot_q     <= lroot_d;
      extra_q     <= extra_d;
      pend_q      <= pend_d;
      crem_q      <= crem_d;
      cdist_q     <= cdist_d;
      lit_pend_q  <= lit_pend_d;
      lit_q       <= lit_d;
      hpos_q      <= hpos_d;
      n_q         <= n_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/vpk0_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vpk0_emit (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic st_push_i,
  input  wire vpk0_pkg::status_t   st_i,
  input  wire                logic bq_push_i,
  input  wire                logic [7:0] bq_byte_i,
  output logic                     space_ok_o,
  output logic                     out_valid_o,
  input  wire                logic out_stall_i,
  output vpk0_pkg::out_item_t      out_item_o
);

  logic [7:0]                 bq_mem [vpk0_pkg::BQ_DEPTH];
  logic [7:0]                 bq_rd_q;
  logic [vpk0_pkg::BQ_AW:0]   wptr_q, rptr_q, rptr_d, bq_used;
  logic                       rd_en;

  vpk0_pkg::status_t sq_q [2];
  logic              sq_head_q, sq_tail_q;
  logic [1:0]        sq_cnt_q;
  logic              pop;
  vpk0_pkg::status_t head;

  vpk0_pkg::back_e     b_q, b_d;
  vpk0_pkg::out_item_t out_q, out_d;
  logic [vpk0_pkg::BCNT_W-1:0] rem_q, rem_d;

  assign bq_used    = wptr_q - rptr_q;
  assign space_ok_o = (bq_used <= (vpk0_pkg::BQ_AW + 1)'(vpk0_pkg::MAX_BYTES)) &&
                      (sq_cnt_q != 2'd2);
  assign head       = sq_q[sq_head_q];

  always_ff @(posedge clk_i) begin
    if (bq_push_i) begin
      bq_mem[wptr_q[vpk0_pkg::BQ_AW-1:0]] <= bq_byte_i;
    end
    if (rd_en) begin
      bq_rd_q <= bq_mem[rptr_q[vpk0_pkg::BQ_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_push_i) begin
      sq_q[sq_tail_q] <= st_i;
    end
  end

  always_comb begin
    b_d = b_q;
    unique case (b_q)
      vpk0_pkg::B_IDLE: begin
        if (sq_cnt_q != 2'd0) begin
          b_d = (head.count == '0) ? vpk0_pkg::B_HOLD : vpk0_pkg::B_LOAD;
        end
      end
      vpk0_pkg::B_LOAD: b_d = vpk0_pkg::B_HOLD;
      vpk0_pkg::B_HOLD: begin
        if (!out_stall_i) begin
          b_d = out_q.last ? vpk0_pkg::B_IDLE : vpk0_pkg::B_LOAD;
        end
      end
      default: b_d = vpk0_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    out_d  = out_q;
    rem_d  = rem_q;
    rptr_d = rptr_q;
    rd_en  = 1'b0;
    pop    = 1'b0;
    unique case (b_q)
      vpk0_pkg::B_IDLE: begin
        if (sq_cnt_q != 2'd0) begin
          if (head.count == '0) begin
            out_d.out_byte     = '0;
            out_d.byte_valid   = 1'b0;
            out_d.last         = 1'b1;
            out_d.more_pending = head.more;
            out_d.done_res     = head.done;
            out_d.error_code   = head.err;
          end else begin
            rd_en  = 1'b1;
            rptr_d = rptr_q + 1'b1;
            rem_d  = head.count;
          end
        end
      end
      vpk0_pkg::B_LOAD: begin
        out_d.out_byte     = bq_rd_q;
        out_d.byte_valid   = 1'b1;
        out_d.last         = rem_q == vpk0_pkg::BCNT_W'(1);
        out_d.more_pending = head.more;
        out_d.done_res     = head.done;
        out_d.error_code   = head.err;
        rem_d              = rem_q - 1'b1;
      end
      vpk0_pkg::B_HOLD: begin
        if (!out_stall_i) begin
          if (out_q.last) begin
            pop = 1'b1;
          end else begin
            rd_en  = 1'b1;
            rptr_d = rptr_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = b_q == vpk0_pkg::B_HOLD;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q       <= vpk0_pkg::B_IDLE;
      rem_q     <= '0;
      wptr_q    <= '0;
      rptr_q    <= '0;
      sq_head_q <= 1'b0;
      sq_tail_q <= 1'b0;
      sq_cnt_q  <= 2'd0;
    end else begin
      b_q    <= b_d;
      rem_q  <= rem_d;
      rptr_q <= rptr_d;
      if (bq_push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (st_push_i) begin
        sq_tail_q <= ~sq_tail_q;
      end
      if (pop) begin
        sq_head_q <= ~sq_head_q;
      end
      sq_cnt_q <= sq_cnt_q + {1'b0, st_push_i} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- tb/vpk0_stream_decompressor_tb.sv -----
`timescale 1ns / 1ps

module vpk0_stream_decompressor_tb;

  localparam int  NUM_ITEMS  = 370;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  DRAIN_WAIT = 300;
  localparam int  NO_ROOT    = -1;
  // widths of the two leaves in each prefix tree of the generated stream
  localparam int  OFS_NARROW = 2;
  localparam int  OFS_WIDE   = 9;
  localparam int  LEN_ZERO   = 0;
  localparam int  LEN_WIDE   = 6;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  vpk0_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  vpk0_pkg::out_item_t out_item;

  vpk0_stream_decompressor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror: bit reader, tree builder, symbol decoder and history.
  // ---------------------------------------------------------------------------
  logic [31:0]      bit_buf;
  int               bit_cnt;
  vpk0_pkg::phase_e dec_phase;
  logic [31:0]      decl_size;
  logic [31:0]      out_count;
  bit               two_sample;
  int               nodes_used;
  int               stack_fill;
  bit               node_leaf [vpk0_pkg::NODE_POOL];
  int               node_left [vpk0_pkg::NODE_POOL];
  int               node_right[vpk0_pkg::NODE_POOL];
  logic [7:0]       node_width[vpk0_pkg::NODE_POOL];
  int               build_stk [vpk0_pkg::STACK_DEPTH];
  int               ofs_root;
  int               len_root;
  int               walk_at;
  vpk0_pkg::sub_e   walk_sub;
  int               bits_needed;
  logic [31:0]      field_acc;
  vpk0_pkg::err_e   dec_err;
  longint           extra_back;
  longint           copy_dist_pend;
  logic [31:0]      copy_left;
  logic [31:0]      copy_dist;
  bit               lit_waiting;
  logic [7:0]       lit_value;
  logic [7:0]       history_mem[vpk0_pkg::HISTORY_DEPTH];
  int               hist_wr;

  vpk0_pkg::out_item_t expected_out[$];
  int                  mismatches;
  int                  bytes_seen;
  int                  cycle_count;

  function automatic void need_bits(vpk0_pkg::phase_e p, int n);
    dec_phase   = p;
    bits_needed = n;
    field_acc   = '0;
  endfunction

  function automatic void raise_error(vpk0_pkg::err_e e);
    dec_err   = e;
    dec_phase = vpk0_pkg::PH_ERROR;
  endfunction

  function automatic void visit_node(int n);
    walk_at = n;
    if (node_leaf[n]) need_bits(vpk0_pkg::PH_FIELD, int'(node_width[n]));
    else need_bits(vpk0_pkg::PH_WALK, 1);
  endfunction

  function automatic void start_walk(int root, vpk0_pkg::sub_e s);
    if (root == NO_ROOT) begin
      raise_error(vpk0_pkg::ERR_EMPTY_TREE);
      return;
    end
    walk_sub = s;
    visit_node(root);
  endfunction

  function automatic void tree_step(bit b, bit offs);
    int n;
    int root;
    if (b && stack_fill < 2) begin
      // a join with fewer than two entries closes the tree
      root = (stack_fill != 0) ? build_stk[0] : NO_ROOT;
      stack_fill = 0;
      if (offs) begin
        ofs_root = root;
        need_bits(vpk0_pkg::PH_LTREE, 1);
      end else begin
        len_root = root;
        need_bits(vpk0_pkg::PH_FLAG, 1);
      end
      return;
    end
    if (nodes_used >= vpk0_pkg::NODE_POOL) begin
      raise_error(vpk0_pkg::ERR_OVERFLOW);
      return;
    end
    if (b) begin
      n = nodes_used++;
      node_leaf[n]  = 1'b0;
      node_left[n]  = build_stk[stack_fill-2];
      node_right[n] = build_stk[stack_fill-1];
      node_width[n] = '0;
      build_stk[stack_fill-2] = n;
      stack_fill--;
      need_bits(offs ? vpk0_pkg::PH_OTREE : vpk0_pkg::PH_LTREE, 1);
    end else begin
      if (stack_fill >= vpk0_pkg::STACK_DEPTH) begin
        raise_error(vpk0_pkg::ERR_OVERFLOW);
        return;
      end
      n = nodes_used++;
      node_leaf[n]  = 1'b1;
      node_left[n]  = 0;
      node_right[n] = 0;
      node_width[n] = '0;
      need_bits(offs ? vpk0_pkg::PH_OLEAF : vpk0_pkg::PH_LLEAF, 8);
    end
  endfunction

  function automatic void leaf_width_read(bit offs);
    node_width[nodes_used-1] = field_acc[7:0];
    build_stk[stack_fill++]  = nodes_used - 1;
    need_bits(offs ? vpk0_pkg::PH_OTREE : vpk0_pkg::PH_LTREE, 1);
  endfunction

  function automatic void field_read();
    longint sv;
    sv = longint'({32'b0, field_acc}) - (field_acc[31] ? 64'sh1_0000_0000 : 64'sh0);
    if (walk_sub == vpk0_pkg::SUB_FIRST) begin
      if (two_sample) begin
        if (sv <= 2) begin
          extra_back = sv + 1;
          start_walk(ofs_root, vpk0_pkg::SUB_SECOND);
          return;
        end
        copy_dist_pend = sv * 4 - 8;
      end else begin
        copy_dist_pend = sv;
      end
      start_walk(len_root, vpk0_pkg::SUB_LEN);
    end else if (walk_sub == vpk0_pkg::SUB_SECOND) begin
      copy_dist_pend = sv * 4 + extra_back - 8;
      start_walk(len_root, vpk0_pkg::SUB_LEN);
    end else begin
      if (sv > 0) begin
        if (copy_dist_pend <= 0 || copy_dist_pend > longint'({32'b0, out_count}) ||
            copy_dist_pend > vpk0_pkg::HISTORY_DEPTH) begin
          raise_error(vpk0_pkg::ERR_BAD_OFFSET);
          return;
        end
        copy_left = sv[31:0];
        copy_dist = copy_dist_pend[31:0];
      end
      need_bits(vpk0_pkg::PH_FLAG, 1);
    end
  endfunction

  function automatic void field_complete();
    case (dec_phase)
      vpk0_pkg::PH_MAGIC:  need_bits(vpk0_pkg::PH_SIZE, 32);
      vpk0_pkg::PH_SIZE: begin
        decl_size = field_acc;
        need_bits(vpk0_pkg::PH_METHOD, 8);
      end
      vpk0_pkg::PH_METHOD: begin
        two_sample = (field_acc[7:0] != 8'd0);
        stack_fill = 0;
        need_bits(vpk0_pkg::PH_OTREE, 1);
      end
      vpk0_pkg::PH_OTREE:  tree_step(field_acc[0], 1'b1);
      vpk0_pkg::PH_OLEAF:  leaf_width_read(1'b1);
      vpk0_pkg::PH_LTREE:  tree_step(field_acc[0], 1'b0);
      vpk0_pkg::PH_LLEAF:  leaf_width_read(1'b0);
      vpk0_pkg::PH_FLAG: begin
        if (field_acc[0]) start_walk(ofs_root, vpk0_pkg::SUB_FIRST);
        else need_bits(vpk0_pkg::PH_LITERAL, 8);
      end
      vpk0_pkg::PH_LITERAL: begin
        lit_waiting = 1'b1;
        lit_value   = field_acc[7:0];
        need_bits(vpk0_pkg::PH_FLAG, 1);
      end
      vpk0_pkg::PH_WALK:
        visit_node(field_acc[0] ? node_right[walk_at] : node_left[walk_at]);
      vpk0_pkg::PH_FIELD: field_read();
      default:  raise_error(vpk0_pkg::ERR_OVERFLOW);
    endcase
  endfunction

  function automatic logic [7:0] next_out_byte();
    logic [7:0] b;
    int rd;
    if (lit_waiting) begin
      b = lit_value;
      lit_waiting = 1'b0;
    end else begin
      rd = (hist_wr + vpk0_pkg::HISTORY_DEPTH - int'(copy_dist)) % vpk0_pkg::HISTORY_DEPTH;
      b  = history_mem[rd];
      copy_left--;
    end
    history_mem[hist_wr] = b;
    hist_wr = (hist_wr + 1) % vpk0_pkg::HISTORY_DEPTH;
    if (out_count != 32'hFFFF_FFFF) out_count++;
    return b;
  endfunction

  function automatic bit bytes_waiting();
    return lit_waiting || (copy_left != 0);
  endfunction

  function automatic void decoder_reset();
    bit_buf = '0; bit_cnt = 0; decl_size = '0; out_count = '0; two_sample = 1'b0;
    nodes_used = 0; stack_fill = 0; ofs_root = NO_ROOT; len_root = NO_ROOT;
    walk_at = 0; walk_sub = vpk0_pkg::SUB_FIRST; dec_err = vpk0_pkg::ERR_NONE;
    extra_back = 0; copy_dist_pend = 0; copy_left = '0; copy_dist = '0;
    lit_waiting = 1'b0; lit_value = '0; hist_wr = 0;
    need_bits(vpk0_pkg::PH_MAGIC, 32);
  endfunction

  // Run one accepted transaction through the mirror and queue its results.
  function automatic void decode_transaction(vpk0_pkg::in_item_t it, bit push);
    logic [7:0]          got[$];
    vpk0_pkg::out_item_t r;
    int                  cnt;
    if (it.cmd == vpk0_pkg::CMD_SUPPLY && !bytes_waiting() &&
        dec_phase != vpk0_pkg::PH_DONE && dec_phase != vpk0_pkg::PH_ERROR &&
        bit_cnt <= 16) begin
      bit_buf = {bit_buf[15:0], it.word};
      bit_cnt += 16;
    end
    while (1) begin
      if (dec_phase == vpk0_pkg::PH_DONE || dec_phase == vpk0_pkg::PH_ERROR) break;
      if (bytes_waiting()) begin
        if (got.size() >= vpk0_pkg::MAX_BYTES) break;
        got.push_back(next_out_byte());
        continue;
      end
      if (dec_phase == vpk0_pkg::PH_FLAG && out_count >= decl_size) begin
        dec_phase = vpk0_pkg::PH_DONE;
        continue;
      end
      if (bits_needed == 0) begin
        field_complete();
        continue;
      end
      if (bit_cnt == 0) break;
      field_acc = {field_acc[30:0], bit_buf[bit_cnt-1]};
      bit_cnt--;
      bits_needed--;
    end
    cnt = (got.size() != 0) ? got.size() : 1;
    for (int k = 0; k < cnt; k++) begin
      r.out_byte     = (k < got.size()) ? got[k] : 8'd0;
      r.byte_valid   = (k < got.size());
      r.last         = (k == cnt - 1);
      r.more_pending = bytes_waiting();
      r.done_res     = (dec_phase == vpk0_pkg::PH_DONE);
      r.error_code   = dec_err;
      if (push) expected_out.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stream builder: header, two-leaf trees, literals and valid copies, then one bad copy.
  // ---------------------------------------------------------------------------
  bit          stream_bits[$];
  logic [15:0] stream_words[$];
  int          gen_count;

  function automatic void put_field(logic [31:0] v, int w);
    for (int i = w - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endfunction

  function automatic void put_tree(int wa, int wb);
    stream_bits.push_back(1'b0); put_field(wa, 8);
    stream_bits.push_back(1'b0); put_field(wb, 8);
    stream_bits.push_back(1'b1);
    stream_bits.push_back(1'b1);
  endfunction

  // Encode distance d with the two-sample rule: a multiple of four uses the
  // wide leaf alone, anything else goes through the narrow leaf first.
  function automatic void put_distance(int d);
    int ex;
    if (d % 4 == 0) begin
      stream_bits.push_back(1'b1); put_field((d + 8) / 4, OFS_WIDE);
    end else begin
      ex = d % 4;
      stream_bits.push_back(1'b0); put_field(ex - 1, OFS_NARROW);
      stream_bits.push_back(1'b1); put_field((d + 8 - ex) / 4, OFS_WIDE);
    end
  endfunction

  function automatic void build_stream();
    int d;
    int len;
    put_field(32'hFFFF_0000, 32);           // magic, all ones then all zeros
    put_field(32'hFFFF_FFFF, 32);           // size never reached
    put_field($urandom_range(255, 1), 8);   // two-sample method
    put_tree(OFS_NARROW, OFS_WIDE);
    put_tree(LEN_ZERO, LEN_WIDE);
    gen_count = 0;
    while (stream_bits.size() < (NUM_ITEMS - 20) * 16) begin
      if (gen_count == 0 || $urandom_range(99) < 40) begin
        stream_bits.push_back(1'b0);
        put_field($urandom_range(255), 8);
        gen_count++;
      end else begin
        stream_bits.push_back(1'b1);
        d = $urandom_range((gen_count < 1000) ? gen_count : 1000, 1);
        put_distance(d);
        if ($urandom_range(99) < 15) begin
          stream_bits.push_back(1'b0);       // zero-width length
        end else begin
          len = $urandom_range(63, 1);
          stream_bits.push_back(1'b1); put_field(len, LEN_WIDE);
          gen_count += len;
        end
      end
    end
    // close with a copy whose distance is negative
    stream_bits.push_back(1'b1);
    stream_bits.push_back(1'b0); put_field(0, OFS_NARROW);
    stream_bits.push_back(1'b1); put_field(0, OFS_WIDE);
    stream_bits.push_back(1'b1); put_field(5, LEN_WIDE);
    while (stream_bits.size() % 16 != 0 || stream_bits.size() < NUM_ITEMS * 16)
      stream_bits.push_back(1'($urandom_range(1)));
    for (int i = 0; i < stream_bits.size(); i += 16) begin
      logic [15:0] w;
      for (int j = 0; j < 16; j++) w[15-j] = stream_bits[i+j];
      stream_words.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern is drawn anew every window; one long hold on request.
  // ---------------------------------------------------------------------------
  bit hold_req;
  bit hold_taken;
  int hold_cnt;
  int window_cnt;
  int stall_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      hold_cnt   <= 0;
      hold_taken <= 1'b0;
      window_cnt <= 0;
      stall_mode <= 0;
    end else begin
      window_cnt <= window_cnt + 1;
      if (window_cnt % 64 == 0) stall_mode <= $urandom_range(2);
      if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_taken) begin
        // hold off long enough for the byte queue and input stage to fill
        hold_taken <= 1'b1;
        hold_cnt   <= 800;
        out_stall  <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(99) < 30);
          default: out_stall <= ($urandom_range(99) < 75);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_out.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %p", $time, out_item);
      end else begin
        vpk0_pkg::out_item_t e;
        e = expected_out.pop_front();
        if (out_item.byte_valid) bytes_seen++;
        if (out_item.out_byte !== e.out_byte || out_item.byte_valid !== e.byte_valid ||
            out_item.last !== e.last || out_item.more_pending !== e.more_pending ||
            out_item.done_res !== e.done_res || out_item.error_code !== e.error_code) begin
          mismatches++;
          $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  typedef struct {
    vpk0_pkg::in_item_t  item;
    bit                  fixed;     // expectation typed in rather than predicted
    vpk0_pkg::out_item_t result;
  } stim_row_t;

  stim_row_t directed_rows[$];
  int        word_idx;
  int        burst_left;
  int        items_sent;
  int        drains_sent;

  // Offer one transaction, hold it until accepted, then predict.
  task automatic send_item(vpk0_pkg::in_item_t it, bit fixed,
                           vpk0_pkg::out_item_t fixed_res);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(8, 1);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(24, 1);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (it.cmd == vpk0_pkg::CMD_DRAIN) drains_sent++;
    decode_transaction(it, !fixed);
    if (fixed) expected_out.push_back(fixed_res);
  endtask

  // Next stream word, or a drain while decoded bytes wait; now and then offer
  // a stray word while paused, which the block must treat as a drain.
  task automatic send_next();
    vpk0_pkg::in_item_t  it;
    vpk0_pkg::out_item_t none;
    none = '0;
    if (bytes_waiting()) begin
      it.cmd  = ($urandom_range(99) < 10) ? vpk0_pkg::CMD_SUPPLY : vpk0_pkg::CMD_DRAIN;
      it.word = 16'($urandom_range(16'hFFFF));
    end else begin
      it.cmd  = vpk0_pkg::CMD_SUPPLY;
      it.word = stream_words[word_idx++];
    end
    send_item(it, 1'b0, none);
  endtask

  initial begin
    stim_row_t           row;
    vpk0_pkg::out_item_t idle_status;

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    hold_req  = 1'b0;
    items_sent  = 0;
    drains_sent = 0;
    burst_left  = 0;
    word_idx    = 0;
    decoder_reset();
    build_stream();

    // Header transactions give one status-only result, last set and all status flags clear.
    idle_status      = '0;
    idle_status.last = 1'b1;
    for (int i = 0; i < 2; i++) begin
      row.item   = '{cmd: vpk0_pkg::CMD_SUPPLY, word: stream_words[word_idx++]};
      row.fixed  = 1'b1;
      row.result = idle_status;
      directed_rows.push_back(row);
    end
    row.item = '{cmd: vpk0_pkg::CMD_DRAIN, word: 16'hFFFF};   // drain with nothing waiting
    directed_rows.push_back(row);
    for (int i = 0; i < 2; i++) begin
      row.item = '{cmd: vpk0_pkg::CMD_SUPPLY, word: stream_words[word_idx++]};
      directed_rows.push_back(row);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);
    // method, trees and first symbols through the predictor
    while (items_sent < 25) send_next();

    while (word_idx < stream_words.size() || bytes_waiting()) begin
      if (items_sent == 150) hold_req = 1'b1;
      if (items_sent == 260) begin
        in_valid <= 1'b0;
        burst_left = $urandom_range(24, 1);
        while (expected_out.size() != 0) @(posedge clk_i);
      end
      send_next();
    end
    in_valid <= 1'b0;

    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d transactions (%0d drains), checked %0d decoded bytes.",
             items_sent, drains_sent, bytes_seen);
    $display("Final error code %0d, mismatches %0d.", dec_err, mismatches);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
